/* hdl/mspc_pkg.sv */
package mspc_pkg;

   // field widths
   localparam int PERIOD_WIDTH = 32;
   localparam int SPEED_WIDTH  = 30;
   localparam int TARGET_WIDTH = 30;
   localparam int ERROR_WIDTH  = 31;
   localparam int DRIVE_WIDTH  = 12;
   localparam int INTEG_WIDTH  = 21;
   localparam int COUNT_WIDTH  = 5;

   // numerator of the speed division, also the saturated speed
   localparam logic [SPEED_WIDTH-1:0] SPEED_NUM = 30'd1000000000;
   localparam logic [COUNT_WIDTH-1:0] DIV_LAST  = COUNT_WIDTH'(SPEED_WIDTH - 1);

   // controller constants
   localparam logic signed [32:0] DRIVE_CENTER = 33'sd2048;
   localparam logic signed [32:0] DRIVE_MAX    = 33'sd4095;
   localparam logic signed [31:0] INTEG_LIMIT  = 32'sd1000000;
   localparam int                 INTEG_SHIFT  = 7;

   // controls from the sequencer to the controller datapath
   typedef struct packed {
      logic load_err;
      logic commit;
   } pi_ctrl_type;

endpackage

/* hdl/mspc_divider.sv */
module mspc_divider
   import mspc_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic [PERIOD_WIDTH-1:0] divisor,
   output logic                    done,
   output logic [SPEED_WIDTH-1:0]  quotient
);

   logic                    busy_ff, busy_in;
   logic                    done_ff, done_in;
   logic [COUNT_WIDTH-1:0]  count_ff, count_in;
   logic [SPEED_WIDTH-1:0]  num_ff, num_in;
   logic [SPEED_WIDTH-1:0]  quo_ff, quo_in;
   logic [PERIOD_WIDTH-1:0] rem_ff, rem_in;
   logic [PERIOD_WIDTH-1:0] dvs_ff, dvs_in;
   logic                    zero_ff, zero_in;
   logic [PERIOD_WIDTH:0]   trial;
   logic [PERIOD_WIDTH+1:0] diff;
   logic                    borrow;

   // one restoring step: bring down the next numerator bit, try the subtract
   always_comb begin
      trial  = {rem_ff, num_ff[SPEED_WIDTH-1]};
      diff   = {1'b0, trial} - {2'b00, dvs_ff};
      borrow = diff[PERIOD_WIDTH+1];
   end

   // step sequencing
   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      num_in   = num_ff;
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      dvs_in   = dvs_ff;
      zero_in  = zero_ff;
      if (start) begin
         busy_in  = 1'b1;
         count_in = '0;
         num_in   = SPEED_NUM;
         quo_in   = '0;
         rem_in   = '0;
         dvs_in   = divisor;
         zero_in  = (divisor == '0);
      end else if (busy_ff) begin
         num_in   = {num_ff[SPEED_WIDTH-2:0], 1'b0};
         quo_in   = {quo_ff[SPEED_WIDTH-2:0], ~borrow};
         rem_in   = borrow ? trial[PERIOD_WIDTH-1:0] : diff[PERIOD_WIDTH-1:0];
         count_in = count_ff + COUNT_WIDTH'(1);
         if (count_ff == DIV_LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      num_ff  <= num_in;
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      dvs_ff  <= dvs_in;
      zero_ff <= zero_in;
   end

   // a zero period saturates the speed
   assign done     = done_ff;
   assign quotient = zero_ff ? SPEED_NUM : quo_ff;

`ifndef ASSERT_OFF
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (count_ff <= DIV_LAST))
      else $error("divider step count past last bit");
`endif

endmodule

/* hdl/mspc_pi_unit.sv */
module mspc_pi_unit
   import mspc_pkg::*;
(
   input  logic                           clock,
   input  logic                           reset,
   input  pi_ctrl_type                    ctrl,
   input  logic [SPEED_WIDTH-1:0]         speed,
   input  logic [TARGET_WIDTH-1:0]        target,
   output logic [DRIVE_WIDTH-1:0]         drive_level,
   output logic signed [ERROR_WIDTH-1:0]  speed_error
);

   logic signed [ERROR_WIDTH-1:0] err_ff, err_in;
   logic signed [INTEG_WIDTH-1:0] integ_ff, integ_in;
   logic signed [INTEG_WIDTH-1:0] biased;
   logic signed [INTEG_WIDTH-INTEG_SHIFT-1:0] integ_quot;
   logic signed [32:0] drive_sum;
   logic signed [31:0] acc;

   // speed minus target, fits 31 signed bits for any 30-bit operands
   assign err_in = $signed({1'b0, speed}) - $signed({1'b0, target});

   // integral / 128 truncated toward zero: bias negatives before the shift
   always_comb begin
      biased     = integ_ff + $signed({{(INTEG_WIDTH-INTEG_SHIFT){1'b0}},
                                       {INTEG_SHIFT{integ_ff[INTEG_WIDTH-1]}}});
      integ_quot = biased[INTEG_WIDTH-1:INTEG_SHIFT];
   end

   // drive level with clamp
   always_comb begin
      drive_sum = DRIVE_CENTER + 33'(err_ff) + 33'(integ_quot);
      if (drive_sum < 33'sd0) begin
         drive_level = '0;
      end else if (drive_sum > DRIVE_MAX) begin
         drive_level = DRIVE_MAX[DRIVE_WIDTH-1:0];
      end else begin
         drive_level = drive_sum[DRIVE_WIDTH-1:0];
      end
   end

   // integral update with clamp
   always_comb begin
      acc      = 32'(integ_ff) + 32'(err_ff);
      integ_in = integ_ff;
      if (ctrl.commit) begin
         if (acc > INTEG_LIMIT) begin
            integ_in = INTEG_LIMIT[INTEG_WIDTH-1:0];
         end else if (acc < -INTEG_LIMIT) begin
            integ_in = INTEG_WIDTH'(-INTEG_LIMIT);
         end else begin
            integ_in = acc[INTEG_WIDTH-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         integ_ff <= '0;
      end else begin
         integ_ff <= integ_in;
      end
      if (ctrl.load_err) begin
         err_ff <= err_in;
      end
   end

   assign speed_error = err_ff;

`ifndef ASSERT_OFF
   a_integ_range: assert property (@(posedge clock) disable iff (reset)
      (32'(integ_ff) <= INTEG_LIMIT) && (32'(integ_ff) >= -INTEG_LIMIT))
      else $error("integral outside its limit");
`endif

endmodule

/* hdl/motor_speed_pi_controller_core.sv */
// channel   | direction | transfer contents
// ----------+-----------+--------------------------------------------------
// req_      | in        | period_ticks [31:0]
// rsp_      | out       | drive_level [11:0], speed_error [42:12]
// csr_      | in        | target_speed [29:0], written when csr_wr_en is high
//
// each item passes from the req transfer through the bit-serial divider (one
// quotient bit per cycle), a step that forms the error and a step that
// updates drive and integral, before rsp_tvalid. req_tready is high only while
// the sequencer is idle, so a new req transfer can follow only once the last
// item has been committed. a waiting result holds in the output register while
// the next item divides; the update stalls until that result is taken.
// synchronous reset clears target speed, integral and all control state.
module motor_speed_pi_controller_core
   import mspc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // period_ticks [31:0]
   input  logic [31:0] req_tdata,
   input  logic        req_tvalid,
   output logic        req_tready,
   // drive_level [11:0], speed_error [42:12], zero [47:43]
   output logic [47:0] rsp_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic        csr_wr_en,
   input  logic [29:0] csr_wr_data
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_DIVIDE,
      S_UPDATE
   } state_type;

   state_type                   state_ff;
   logic                        rsp_valid_ff;
   logic [47:0]                 rsp_data_ff;
   logic [TARGET_WIDTH-1:0]     target_ff;
   logic                        req_xfer;
   logic                        rsp_free;
   logic                        div_done;
   logic [SPEED_WIDTH-1:0]      speed;
   pi_ctrl_type                 pi_ctrl;
   logic [DRIVE_WIDTH-1:0]      drive_level;
   logic signed [ERROR_WIDTH-1:0] speed_error;

   assign req_tready = (state_ff == S_IDLE);
   assign req_xfer   = req_tvalid && req_tready;
   assign rsp_free   = !rsp_valid_ff || rsp_tready;

   // controls to the controller datapath
   always_comb begin
      pi_ctrl.load_err = (state_ff == S_DIVIDE) && div_done;
      pi_ctrl.commit   = (state_ff == S_UPDATE) && rsp_free;
   end

   mspc_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (req_xfer),
      .divisor  (req_tdata),
      .done     (div_done),
      .quotient (speed)
   );

   mspc_pi_unit u_pi_unit (
      .clock       (clock),
      .reset       (reset),
      .ctrl        (pi_ctrl),
      .speed       (speed),
      .target      (target_ff),
      .drive_level (drive_level),
      .speed_error (speed_error)
   );

   // target speed register
   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff <= '0;
      end else if (csr_wr_en) begin
         target_ff <= csr_wr_data;
      end
   end

   // sequencer and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (pi_ctrl.commit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_xfer) begin
                  state_ff <= S_DIVIDE;
               end
            end
            S_DIVIDE: begin
               if (div_done) begin
                  state_ff <= S_UPDATE;
               end
            end
            S_UPDATE: begin
               if (rsp_free) begin
                  state_ff <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
      if (pi_ctrl.commit) begin
         rsp_data_ff <= {5'b00000, speed_error, drive_level};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

`ifndef ASSERT_OFF
   a_done_in_divide: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == S_DIVIDE))
      else $error("divider finished outside the divide state");

   a_commit_free: assert property (@(posedge clock) disable iff (reset)
      pi_ctrl.commit |-> (!rsp_valid_ff || rsp_tready))
      else $error("result written over a waiting result");

   a_commit_shows: assert property (@(posedge clock) disable iff (reset)
      pi_ctrl.commit |=> rsp_valid_ff && (state_ff == S_IDLE))
      else $error("committed result not presented");
`endif

endmodule

/* tb/sv/tb_motor_speed_pi_controller_core.sv */
`timescale 1ns / 1ps

module tb_motor_speed_pi_controller_core;
   import mspc_pkg::*;

   localparam int    DRAIN_CYCLES   = 40;
   localparam int    CYCLE_LIMIT    = 1000000;
   localparam int    LONG_HOLD      = 300;
   localparam int    PHASE_COUNT    = 13;
   localparam int    PHASE_ITEMS    = 150;
   localparam int    MAX_PRINTS     = 20;
   localparam longint SPEED_FULL    = 1000000000;
   localparam logic [TARGET_WIDTH-1:0] TARGET_TOP = '1;

   // one drive command with its speed error
   typedef struct {
      logic [DRIVE_WIDTH-1:0]        drive;
      logic signed [ERROR_WIDTH-1:0] err;
   } pi_result_type;

   typedef enum logic [1:0] {ROW_PERIOD, ROW_CHECKED, ROW_TARGET} row_kind_type;

   typedef struct {
      row_kind_type                  kind;
      logic [PERIOD_WIDTH-1:0]       value;
      logic [DRIVE_WIDTH-1:0]        drive;
      logic signed [ERROR_WIDTH-1:0] err;
   } stim_row_type;

   logic                    clock       = 1'b0;
   logic                    reset       = 1'b1;
   logic [31:0]             req_tdata   = '0;
   logic                    req_tvalid  = 1'b0;
   logic                    req_tready;
   logic [47:0]             rsp_tdata;
   logic                    rsp_tvalid;
   logic                    rsp_tready  = 1'b0;
   logic                    csr_wr_en   = 1'b0;
   logic [29:0]             csr_wr_data = '0;

   // predictor state
   logic [TARGET_WIDTH-1:0]       model_target;
   logic signed [INTEG_WIDTH-1:0] model_integral;

   pi_result_type pending_results [$];
   stim_row_type  directed_rows [$];

   int  error_count    = 0;
   int  periods_sent   = 0;
   int  results_seen   = 0;
   int  target_writes  = 0;
   int  cycle_count    = 0;
   int  drive_low_hits = 0;
   int  drive_top_hits = 0;
   int  drive_mid_hits = 0;
   bit  hold_off_trigger = 1'b0;

   motor_speed_pi_controller_core i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tdata   (req_tdata),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #5 clock = ~clock;

   // one controller step: speed from the period, error, clamped drive, integral update
   function automatic pi_result_type predict_pi_step(input logic [PERIOD_WIDTH-1:0] period);
      pi_result_type res;
      longint     speed;
      longint     err;
      longint     drive;
      longint     integ;
      longint     acc;
      speed = (period == '0) ? SPEED_FULL : SPEED_FULL / longint'({32'b0, period});
      err   = speed - longint'({34'b0, model_target});
      integ = longint'(model_integral);
      drive = longint'(DRIVE_CENTER) + err + integ / (longint'(1) << INTEG_SHIFT);
      if (drive > longint'(DRIVE_MAX)) drive = longint'(DRIVE_MAX);
      if (drive < 0) drive = 0;
      acc = integ + err;
      if (acc > longint'(INTEG_LIMIT)) acc = longint'(INTEG_LIMIT);
      if (acc < -longint'(INTEG_LIMIT)) acc = -longint'(INTEG_LIMIT);
      model_integral = INTEG_WIDTH'(acc);
      res.drive = DRIVE_WIDTH'(drive);
      res.err   = ERROR_WIDTH'(err);
      return res;
   endfunction

   task automatic report_mismatch(input string what, input longint want, input longint got);
      error_count++;
      if (error_count <= MAX_PRINTS) begin
         $display("[%0t] mismatch on %s: expected %0d, got %0d", $realtime, what, want, got);
      end
   endtask

   task automatic add_period(input logic [31:0] p);
      stim_row_type row;
      row.kind  = ROW_PERIOD;
      row.value = p;
      row.drive = '0;
      row.err   = '0;
      directed_rows.push_back(row);
   endtask

   task automatic add_checked(input logic [31:0] p, input int d, input longint e);
      stim_row_type row;
      row.kind  = ROW_CHECKED;
      row.value = p;
      row.drive = DRIVE_WIDTH'(d);
      row.err   = ERROR_WIDTH'(e);
      directed_rows.push_back(row);
   endtask

   task automatic add_target(input logic [29:0] t);
      stim_row_type row;
      row.kind  = ROW_TARGET;
      row.value = {2'b0, t};
      row.drive = '0;
      row.err   = '0;
      directed_rows.push_back(row);
   endtask

   // offer one period and hold it until the transfer; the prediction follows the transfer
   task automatic send_period(input logic [31:0] p, input bit use_typed,
                              input pi_result_type typed);
      pi_result_type predicted;
      req_tdata  <= p;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      predicted = predict_pi_step(p);
      pending_results.push_back(use_typed ? typed : predicted);
      periods_sent++;
   endtask

   // block is drained before any register write
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_target(input logic [29:0] t);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= t;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      model_target = t;
      target_writes++;
   endtask

   function automatic logic [29:0] pick_target(input int phase);
      logic [29:0] t;
      case (phase % 6)
         0: t = (phase % 12 == 0) ? TARGET_TOP : 30'd1000000000;
         1, 2, 3: t = 30'($urandom_range(1000, 200000));
         4: t = 30'($urandom_range(0, 1000000000));
         default: t = 30'($urandom());
      endcase
      if (phase == 9) t = '0;
      return t;
   endfunction

   // about half the periods near the balance point so that drive and integral move freely
   function automatic logic [31:0] pick_period(input logic [29:0] t);
      longint nominal;
      longint spread;
      longint p;
      logic [31:0] res;
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4: begin
            if (t == '0 || longint'({34'b0, t}) > SPEED_FULL) begin
               res = $urandom();
            end else begin
               nominal = SPEED_FULL / longint'({34'b0, t});
               spread  = nominal / 64 + 1;
               p = nominal + longint'($urandom_range(0, 32'(2 * spread))) - spread;
               if (p < 0) p = 0;
               res = 32'(p);
            end
         end
         5: res = $urandom();
         6: res = 32'($urandom_range(0, 16));
         7: res = 32'hFFFF_FFFF - 32'($urandom_range(0, 255));
         8: res = 32'(SPEED_FULL) + 32'($urandom_range(0, 4)) - 32'd2;
         default: res = 32'd1 << $urandom_range(0, 31);
      endcase
      return res;
   endfunction

   // cycle limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycle_count, pending_results.size());
         $display("Some tests failed");
         $finish;
      end
   end

   // receiver: own stall pattern, plus one long hold-off on request
   initial begin : rsp_side
      int  mode;
      int  mode_left;
      int  tick;
      int  hold_left;
      bit  seen_trigger;
      mode = 0;
      mode_left = 0;
      tick = 0;
      hold_left = 0;
      seen_trigger = 1'b0;
      forever begin
         @(posedge clock);
         tick++;
         if (hold_off_trigger != seen_trigger) begin
            seen_trigger = hold_off_trigger;
            hold_left = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            if (mode_left == 0) begin
               mode = $urandom_range(0, 3);
               mode_left = $urandom_range(16, 128);
            end
            mode_left--;
            case (mode)
               0: rsp_tready <= 1'b1;
               1: rsp_tready <= 1'($urandom_range(0, 1));
               2: rsp_tready <= (tick % 3 == 0);
               default: rsp_tready <= ($urandom_range(0, 7) != 0);
            endcase
         end
      end
   end

   // result check against the oldest expectation
   always @(posedge clock) begin : check_results
      pi_result_type           want;
      logic [DRIVE_WIDTH-1:0]  got_drive;
      logic signed [ERROR_WIDTH-1:0] got_err;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got_drive = rsp_tdata[11:0];
         got_err   = rsp_tdata[42:12];
         results_seen++;
         if (got_drive == '0) drive_low_hits++;
         else if (got_drive == '1) drive_top_hits++;
         else drive_mid_hits++;
         if (pending_results.size() == 0) begin
            report_mismatch("unexpected result transfer", 0, 1);
         end else begin
            want = pending_results.pop_front();
            if (got_drive !== want.drive)
               report_mismatch("drive_level", longint'(want.drive), longint'(got_drive));
            if (got_err !== want.err)
               report_mismatch("speed_error", longint'(want.err), longint'(got_err));
         end
      end
   end

   // stimulus
   initial begin : req_side
      pi_result_type typed;
      pi_result_type unused;
      logic [29:0] t;
      int          burst_left;
      int          gap;
      model_target   = '0;
      model_integral = '0;
      unused.drive   = '0;
      unused.err     = '0;

      // target is zero after reset
      add_checked(32'd0, 4095, 1000000000);
      add_checked(32'd1, 4095, 1000000000);
      add_period(32'hFFFF_FFFF);
      add_period(32'd1000000000);
      add_period(32'd999999999);
      add_period(32'd1000000001);
      add_period(32'd2);
      add_period(32'h8000_0000);
      // target above the speed range drives the error to its most negative
      add_target(TARGET_TOP);
      add_checked(32'hFFFF_FFFF, 0, -1073741823);
      add_checked(32'hFFFF_FFFF, 0, -1073741823);
      add_checked(32'd0, 0, -73741823);
      add_target(30'd1000000000);
      add_period(32'd0);
      add_period(32'd1);
      add_checked(32'hFFFF_FFFF, 0, -1000000000);
      // target mid range, small errors around balance
      add_target(30'd500000);
      add_period(32'd2000);
      add_period(32'd1999);
      add_period(32'd2001);
      add_period(32'd1990);
      add_period(32'd2010);
      add_period(32'd2000);
      add_target(30'd0);
      add_period(32'h5555_5555);

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         case (directed_rows[i].kind)
            ROW_TARGET: begin
               wait_idle();
               write_target(directed_rows[i].value[29:0]);
            end
            ROW_CHECKED: begin
               typed.drive = directed_rows[i].drive;
               typed.err   = directed_rows[i].err;
               send_period(directed_rows[i].value, 1'b1, typed);
            end
            default: send_period(directed_rows[i].value, 1'b0, unused);
         endcase
      end

      // random phases, each with its own target
      burst_left = 0;
      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         wait_idle();
         t = pick_target(phase);
         write_target(t);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (phase == PHASE_COUNT / 2 && n == 10) begin
               hold_off_trigger = ~hold_off_trigger;
            end
            if (burst_left == 0) begin
               gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
               if (gap > 0) begin
                  req_tvalid <= 1'b0;
                  repeat (gap) @(posedge clock);
               end
               burst_left = $urandom_range(1, 30);
            end
            burst_left--;
            send_period(pick_period(t), 1'b0, unused);
         end
      end

      // drain
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("sent %0d periods over %0d target settings, checked %0d results",
               periods_sent, target_writes, results_seen);
      $display("drive at zero %0d, at full scale %0d, in between %0d",
               drive_low_hits, drive_top_hits, drive_mid_hits);
      if (error_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("%0d mismatches", error_count);
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
